// ----- rtl/sitda_pkg.sv -----
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Double-dabble bits consumed per conversion cycle
    localparam int DD_BITS_PER_CYCLE = 8;

    // log10(2) ~= 1233 / 2^12, used to size the BCD register
    localparam int LOG10_2_NUM   = 1233;
    localparam int LOG10_2_SHIFT = 12;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;        // capture input word, start conversion
        logic conv;        // one double-dabble step
        logic scan;        // locate leading nonzero digit
        logic emit_sign;   // load '-' into output register
        logic emit_digit;  // load current digit into output register
    } sitda_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic conv_last;   // current step is the final conversion step
        logic negative;    // captured value is negative
        logic idx_zero;    // current digit is the least significant one
        logic out_free;    // output register can take a word this cycle
    } sitda_status_t;

endpackage

// ----- rtl/sitda_datapath.sv -----
// Datapath: magnitude, shift-and-add-3 BCD conversion, digit select, output register.
`timescale 1ns / 1ps

module sitda_datapath import sitda_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic signed [VALUE_BITS-1:0] s_value,
    input  sitda_cmd_t                   cmd,
    output sitda_status_t                status,
    output logic [7:0]                   m_character,
    output logic                         m_last,
    output logic                         m_valid,
    input  logic                         m_ready
);

    localparam int STEPS = (VALUE_BITS + DD_BITS_PER_CYCLE - 1) / DD_BITS_PER_CYCLE;
    localparam int PAD_W = STEPS * DD_BITS_PER_CYCLE;
    localparam int NDIG  = ((VALUE_BITS * LOG10_2_NUM) >> LOG10_2_SHIFT) + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [VALUE_BITS-1:0]   raw;
    logic [VALUE_BITS-1:0]   mag;
    logic [PAD_W-1:0]        shift_reg, shift_next, sh_w;
    logic [NDIG-1:0][3:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]        bcd_w;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        idx_reg, idx_next, idx_scan;
    logic                    neg_reg, neg_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_char_reg, out_char_next;
    logic                    out_last_reg, out_last_next;

    // magnitude in VALUE_BITS unsigned bits; the most negative value fits
    assign raw = s_value;
    assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    // DD_BITS_PER_CYCLE shift-and-add-3 steps
    always_comb begin
        bcd_w = bcd_reg;
        sh_w  = shift_reg;
        for (int s = 0; s < DD_BITS_PER_CYCLE; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (bcd_w[d*4 +: 4] >= 4'd5) begin
                    bcd_w[d*4 +: 4] = bcd_w[d*4 +: 4] + 4'd3;
                end
            end
            bcd_w = {bcd_w[BCD_W-2:0], sh_w[PAD_W-1]};
            sh_w  = {sh_w[PAD_W-2:0], 1'b0};
        end
    end

    // highest nonzero digit, zero if all digits are zero
    always_comb begin
        idx_scan = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[d] != 4'd0) begin
                idx_scan = IDX_W'(d);
            end
        end
    end

    always_comb begin
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (cmd.load) begin
            shift_next = PAD_W'(mag);
            bcd_next   = '0;
            cnt_next   = CNT_W'(STEPS - 1);
            neg_next   = raw[VALUE_BITS-1];
        end
        if (cmd.conv) begin
            shift_next = sh_w;
            bcd_next   = bcd_w;
            cnt_next   = cnt_reg - CNT_W'(1);
        end
        if (cmd.scan) begin
            idx_next = idx_scan;
        end
        if (cmd.emit_sign) begin
            out_char_next  = CHAR_MINUS;
            out_last_next  = 1'b0;
            out_valid_next = 1'b1;
        end
        if (cmd.emit_digit) begin
            out_char_next  = CHAR_ZERO + {4'd0, bcd_reg[idx_reg]};
            out_last_next  = (idx_reg == '0);
            out_valid_next = 1'b1;
            idx_next       = idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign status.conv_last = (cnt_reg == '0);
    assign status.negative  = neg_reg;
    assign status.idx_zero  = (idx_reg == '0);
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_character = out_char_reg;
    assign m_last      = out_last_reg;
    assign m_valid     = out_valid_reg;

endmodule

// ----- rtl/sitda_ctrl.sv -----
// Controller: sequences load, conversion, digit scan and character emission.
`timescale 1ns / 1ps

module sitda_ctrl import sitda_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sitda_status_t status,
    output sitda_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.idx_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

// ----- rtl/signed_int_to_decimal_ascii_core.sv -----
// Top level: signed integer to decimal ASCII string converter.
// Flow: after the accepting edge, ceil(VALUE_BITS/8) conversion steps (8 bits of
//   shift-and-add-3 per step), then one digit scan, then the output register is loaded.
// Output: N characters per input, N = 1..11 at 32 bits; one character per cycle once
//   emitting while m_ready is high. A new input is taken only after the last character
//   of the previous number is loaded into the output register.
// Reset: aresetn synchronous, active low; clears controller and output valid.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core import sitda_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input word: one signed integer
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    // result words: one ASCII character each, last marks end of number
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_character,
    output logic                         m_last
);

    // Controller owns sequencing; datapath owns all payload storage.
    // The output register sits in the datapath, so the last character of one
    // number can wait on m_ready while the next input word is already taken.
    sitda_cmd_t    cmd;
    sitda_status_t status;

    sitda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Magnitude is formed without overflow, so the most negative value
    // converts exactly; leading zeros are skipped by the digit scan.
    sitda_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cmd         (cmd),
        .status      (status),
        .m_character (m_character),
        .m_last      (m_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

endmodule

// ----- rtl/sitda_checker.sv -----
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps

module sitda_checker import sitda_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_character,
    input logic       m_last
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("output word changed while stalled");

    // only '-' or a digit leaves the block
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == CHAR_MINUS) ||
                    (m_character >= CHAR_ZERO && m_character <= CHAR_ZERO + 8'd9))
        else $error("illegal output character");

    // a minus sign never ends a number
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_character == CHAR_MINUS |-> !m_last)
        else $error("minus sign marked last");

    // no new input while a number is still being emitted
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(m_valid && !m_last))
        else $error("input ready in the middle of a number");

    // an accepted word starts a conversion
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after accept");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb;
    import sitda_pkg::*;

    localparam int VB       = 32;
    localparam int N_TABLE  = 21;
    localparam int N_RANDOM = 450;

    typedef struct {
        logic [7:0] character;
        logic       last;
    } ascii_word_t;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [VB-1:0] s_value = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [7:0]    m_character;
    logic          m_last;

    ascii_word_t char_queue [$];
    ascii_word_t want;
    int          idle_pct    = 28;
    int          mismatches  = 0;
    int          words_sent  = 0;
    int          negatives   = 0;
    int          chars_seen  = 0;
    int          numbers_out = 0;

    // Directed words; text left empty means the decimal spelling model supplies it.
    logic [VB-1:0] dir_value [0:N_TABLE-1] = '{
        32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd9,
        32'h7FFF_FFFF, 32'h8000_0000, -32'd2147483647,
        32'd99, 32'd100, -32'd100, 32'd999999999, 32'd1000000000,
        -32'd999999999, -32'd1000000000, 32'd1234567890,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000
    };
    string dir_text [0:N_TABLE-1] = '{
        "0", "1", "-1", "9", "10", "-9",
        "2147483647", "-2147483648", "-2147483647",
        "", "", "", "", "", "", "", "", "", "", "", ""
    };

    signed_int_to_decimal_ascii_core #(
        .VALUE_BITS(VB)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_character(m_character),
        .m_last     (m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Decimal spelling: sign first, digits most significant first, last on the final digit.
    // Magnitude is taken unsigned, so the most negative value needs no special path.
    function automatic void spell_decimal(input logic [VB-1:0] value);
        logic          negative;
        logic [VB-1:0] mag;
        logic [7:0]    digit_buf [0:23];
        int            n;
        ascii_word_t   w;
        negative = value[VB-1];
        mag      = negative ? (~value + 1'b1) : value;
        n        = 0;
        do begin
            digit_buf[n] = CHAR_ZERO + 8'(mag % 10);
            n++;
            mag = mag / 10;
        end while (mag != 0);
        if (negative) begin
            w.character = CHAR_MINUS;
            w.last      = 1'b0;
            char_queue.push_back(w);
        end
        for (int k = n - 1; k >= 0; k--) begin
            w.character = digit_buf[k];
            w.last      = (k == 0);
            char_queue.push_back(w);
        end
    endfunction

    function automatic void queue_text(input string text);
        ascii_word_t w;
        for (int i = 0; i < text.len(); i++) begin
            w.character = text[i];
            w.last      = (i == text.len() - 1);
            char_queue.push_back(w);
        end
    endfunction

    // Mix of full-range words, short numbers, values at or just below powers of ten and values near the extremes.
    function automatic logic [VB-1:0] rand_value();
        logic [VB-1:0] mag;
        int unsigned   pow;
        pow = 1;
        case ($urandom_range(3))
            0: return $urandom();
            1: mag = $urandom_range(0, 999);
            2: begin
                repeat ($urandom_range(9)) pow = pow * 10;
                mag = pow - $urandom_range(1);
            end
            default: begin
                if ($urandom_range(1))
                    return 32'h7FFF_FFFF - $urandom_range(7);
                return 32'h8000_0000 + $urandom_range(7);
            end
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Offer one word, with a random gap first; expectations are queued on acceptance.
    task automatic send_word(input logic [VB-1:0] value, input string text);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (text.len() != 0)
            queue_text(text);
        else
            spell_decimal(value);
        words_sent++;
        if (value[VB-1])
            negatives++;
    endtask

    task automatic drain();
        while (char_queue.size() != 0) @(posedge aclk);
    endtask

    // Result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            chars_seen++;
            if (m_last)
                numbers_out++;
            if (char_queue.size() == 0) begin
                $error("unexpected word: character %h last %b", m_character, m_last);
                mismatches++;
            end else begin
                want = char_queue.pop_front();
                if (m_character !== want.character) begin
                    $error("character: expected %h, got %h", want.character, m_character);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_TABLE; i++)
            send_word(dir_value[i], dir_text[i]);

        // hold off until the directed words are all out
        s_valid <= 1'b0;
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            idle_pct = (i >= 150 && i < 250) ? 0 : 28;
            if (i == 300) begin
                s_valid <= 1'b0;
                drain();
            end
            send_word(rand_value(), "");
        end
        s_valid <= 1'b0;

        drain();
        repeat (30) @(posedge aclk);

        $display("sent %0d numbers (%0d negative), checked %0d characters in %0d strings",
                 words_sent, negatives, chars_seen, numbers_out);
        if (mismatches == 0) begin
            $display("PASS signed_int_to_decimal_ascii_core");
        end else begin
            $display("FAIL signed_int_to_decimal_ascii_core");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d characters outstanding", char_queue.size());
        $display("FAIL signed_int_to_decimal_ascii_core");
        $finish;
    end

endmodule
